FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared transaction types, command codes, configuration indexes and the bus
// sequencer phase encoding.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd2;
  localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_BEGIN_WR   = 2'd1,
    OP_WRITE_BYTE = 2'd2,
    OP_BEGIN_RD   = 2'd3
  } op_t;

  typedef enum logic {
    CFG_PHASE_TICKS    = 1'b0,
    CFG_ACK_POLL_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    STG_ADDR = 2'd0,
    STG_HI   = 2'd1,
    STG_LO   = 2'd2,
    STG_DATA = 2'd3
  } stage_t;

  typedef enum logic [18:0] {
    PH_IDLE     = 19'h00001,
    PH_START_A  = 19'h00002,
    PH_START_B  = 19'h00004,
    PH_SEND_LO1 = 19'h00008,
    PH_SEND_HI  = 19'h00010,
    PH_SEND_LO2 = 19'h00020,
    PH_ACK_LO   = 19'h00040,
    PH_ACK_HI   = 19'h00080,
    PH_ACK_POLL = 19'h00100,
    PH_WAIT     = 19'h00200,
    PH_RECV_LO  = 19'h00400,
    PH_RECV_HI1 = 19'h00800,
    PH_RECV_HI2 = 19'h01000,
    PH_MACK_LO1 = 19'h02000,
    PH_MACK_HI  = 19'h04000,
    PH_MACK_LO2 = 19'h08000,
    PH_STOP_A   = 19'h10000,
    PH_STOP_B   = 19'h20000,
    PH_STOP_C   = 19'h40000
  } phase_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  slave_addr;
    logic [15:0] reg_addr;
    logic        addr_16bit;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       busy_res;
    logic       data_request;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ack_error;
    logic       done_res;
  } out_item_t;

endpackage

FILE: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the bus phase and transfer state and advances them by one tick for
// each accepted transaction, producing that tick's line levels and status.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  i2cm_pkg::in_item_t  item,
  input  i2cm_pkg::cfg_regs_t cfg,
  output i2cm_pkg::out_item_t result
);
  import i2cm_pkg::*;

  phase_t      bus_phase_r, bus_phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic        error_flag_r, error_flag_nxt;
  logic [15:0] held_reg_addr_r, held_reg_addr_nxt;
  logic        held_wide_addr_r, held_wide_addr_nxt;
  logic        is_read_r, is_read_nxt;
  stage_t      byte_stage_r, byte_stage_nxt;

  logic [15:0] full_len;
  logic [15:0] half_len;
  logic [15:0] quarter_len;
  logic [15:0] tick_inc;
  logic        tick_first;

  assign full_len    = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
  assign half_len    = (full_len[15:1] == 15'd0) ? 16'd1 : {1'b0, full_len[15:1]};
  assign quarter_len = (full_len[15:2] == 14'd0) ? 16'd1 : {2'b00, full_len[15:2]};

  function automatic logic phase_done(input logic [15:0] cnt, input logic [15:0] len);
    return (cnt >= len) || (cnt == 16'd0);
  endfunction

  always_comb begin
    bus_phase_nxt      = bus_phase_r;
    tick_count_nxt     = tick_count_r;
    bit_index_nxt      = bit_index_r;
    shift_byte_nxt     = shift_byte_r;
    bytes_left_nxt     = bytes_left_r;
    poll_count_nxt     = poll_count_r;
    error_flag_nxt     = error_flag_r;
    held_reg_addr_nxt  = held_reg_addr_r;
    held_wide_addr_nxt = held_wide_addr_r;
    is_read_nxt        = is_read_r;
    byte_stage_nxt     = byte_stage_r;
    result             = '0;

    if ((bus_phase_r == PH_IDLE) &&
        ((item.op == OP_BEGIN_WR) || (item.op == OP_BEGIN_RD))) begin
      is_read_nxt        = (item.op == OP_BEGIN_RD);
      held_reg_addr_nxt  = item.reg_addr;
      held_wide_addr_nxt = item.addr_16bit;
      bytes_left_nxt     = item.byte_count;
      error_flag_nxt     = 1'b0;
      poll_count_nxt     = '0;
      byte_stage_nxt     = STG_ADDR;
      shift_byte_nxt     = {item.slave_addr, (item.op == OP_BEGIN_RD)};
      bit_index_nxt      = '0;
      bus_phase_nxt      = PH_START_A;
      tick_count_nxt     = '0;
    end else if ((bus_phase_r == PH_WAIT) && (item.op == OP_WRITE_BYTE)) begin
      byte_stage_nxt = STG_DATA;
      shift_byte_nxt = item.data_byte;
      bit_index_nxt  = '0;
      bus_phase_nxt  = PH_SEND_LO1;
      tick_count_nxt = '0;
    end

    result.busy_res = (bus_phase_nxt != PH_IDLE);
    tick_first      = (tick_count_nxt == 16'd0);
    tick_inc        = tick_count_nxt + 16'd1;

    unique case (bus_phase_nxt)
      PH_IDLE: begin
        result.scl     = 1'b1;
        tick_count_nxt = '0;
      end
      PH_START_A: begin
        result.scl     = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          bus_phase_nxt  = PH_START_B;
          tick_count_nxt = '0;
        end
      end
      PH_START_B: begin
        result.scl     = 1'b1;
        result.sda_low = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          bus_phase_nxt  = PH_SEND_LO1;
          tick_count_nxt = '0;
        end
      end
      PH_SEND_LO1: begin
        result.sda_low = ~shift_byte_nxt[7];
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          bus_phase_nxt  = PH_SEND_HI;
          tick_count_nxt = '0;
        end
      end
      PH_SEND_HI: begin
        result.scl     = 1'b1;
        result.sda_low = ~shift_byte_nxt[7];
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          bus_phase_nxt  = PH_SEND_LO2;
          tick_count_nxt = '0;
        end
      end
      PH_SEND_LO2: begin
        result.sda_low = ~shift_byte_nxt[7];
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          shift_byte_nxt = {shift_byte_nxt[6:0], 1'b0};
          bit_index_nxt  = bit_index_nxt + 4'd1;
          tick_count_nxt = '0;
          if (bit_index_nxt >= 4'd8) begin
            poll_count_nxt = '0;
            bus_phase_nxt  = PH_ACK_LO;
          end else begin
            bus_phase_nxt = PH_SEND_LO1;
          end
        end
      end
      PH_ACK_LO: begin
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, quarter_len)) begin
          bus_phase_nxt  = PH_ACK_HI;
          tick_count_nxt = '0;
        end
      end
      PH_ACK_HI: begin
        result.scl     = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, quarter_len)) begin
          bus_phase_nxt  = PH_ACK_POLL;
          tick_count_nxt = '0;
        end
      end
      PH_ACK_POLL: begin
        result.scl = 1'b1;
        if (!item.sda_in) begin
          poll_count_nxt = '0;
          tick_count_nxt = '0;
          if (is_read_nxt) begin
            if (bytes_left_nxt == 16'd0) begin
              bus_phase_nxt = PH_STOP_A;
            end else begin
              shift_byte_nxt = '0;
              bit_index_nxt  = '0;
              bus_phase_nxt  = PH_RECV_LO;
            end
          end else if ((byte_stage_nxt == STG_ADDR) && held_wide_addr_nxt) begin
            byte_stage_nxt = STG_HI;
            shift_byte_nxt = held_reg_addr_nxt[15:8];
            bit_index_nxt  = '0;
            bus_phase_nxt  = PH_SEND_LO1;
          end else if ((byte_stage_nxt == STG_ADDR) || (byte_stage_nxt == STG_HI)) begin
            byte_stage_nxt = STG_LO;
            shift_byte_nxt = held_reg_addr_nxt[7:0];
            bit_index_nxt  = '0;
            bus_phase_nxt  = PH_SEND_LO1;
          end else begin
            if (byte_stage_nxt == STG_DATA) begin
              bytes_left_nxt = bytes_left_nxt - 16'd1;
            end
            bus_phase_nxt = (bytes_left_nxt == 16'd0) ? PH_STOP_A : PH_WAIT;
          end
        end else if (poll_count_nxt >= cfg.ack_poll_limit) begin
          error_flag_nxt = 1'b1;
          bus_phase_nxt  = PH_STOP_A;
          tick_count_nxt = '0;
        end else begin
          poll_count_nxt = poll_count_nxt + 8'd1;
        end
      end
      PH_WAIT: begin
        result.data_request = 1'b1;
      end
      PH_RECV_LO: begin
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          bus_phase_nxt  = PH_RECV_HI1;
          tick_count_nxt = '0;
        end
      end
      PH_RECV_HI1: begin
        result.scl     = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          bus_phase_nxt  = PH_RECV_HI2;
          tick_count_nxt = '0;
        end
      end
      PH_RECV_HI2: begin
        result.scl = 1'b1;
        if (tick_first) begin
          shift_byte_nxt = {shift_byte_nxt[6:0], item.sda_in};
          bit_index_nxt  = bit_index_nxt + 4'd1;
          if (bit_index_nxt >= 4'd8) begin
            result.rx_valid = 1'b1;
            result.rx_byte  = shift_byte_nxt;
            bytes_left_nxt  = bytes_left_nxt - 16'd1;
          end
        end
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          bus_phase_nxt  = (bit_index_nxt >= 4'd8) ? PH_MACK_LO1 : PH_RECV_LO;
          tick_count_nxt = '0;
        end
      end
      PH_MACK_LO1: begin
        result.sda_low = (bytes_left_nxt != 16'd0);
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          bus_phase_nxt  = PH_MACK_HI;
          tick_count_nxt = '0;
        end
      end
      PH_MACK_HI: begin
        result.scl     = 1'b1;
        result.sda_low = (bytes_left_nxt != 16'd0);
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          bus_phase_nxt  = PH_MACK_LO2;
          tick_count_nxt = '0;
        end
      end
      PH_MACK_LO2: begin
        result.sda_low = (bytes_left_nxt != 16'd0);
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          tick_count_nxt = '0;
          if (bytes_left_nxt == 16'd0) begin
            bus_phase_nxt = PH_STOP_A;
          end else begin
            shift_byte_nxt = '0;
            bit_index_nxt  = '0;
            bus_phase_nxt  = PH_RECV_LO;
          end
        end
      end
      PH_STOP_A: begin
        result.sda_low = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          bus_phase_nxt  = PH_STOP_B;
          tick_count_nxt = '0;
        end
      end
      PH_STOP_B: begin
        result.scl     = 1'b1;
        result.sda_low = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, half_len)) begin
          bus_phase_nxt  = PH_STOP_C;
          tick_count_nxt = '0;
        end
      end
      PH_STOP_C: begin
        result.scl     = 1'b1;
        tick_count_nxt = tick_inc;
        if (phase_done(tick_inc, full_len)) begin
          result.done_res = 1'b1;
          bus_phase_nxt   = PH_IDLE;
          tick_count_nxt  = '0;
        end
      end
      default: begin
        result.scl     = 1'b1;
        bus_phase_nxt  = PH_IDLE;
        tick_count_nxt = '0;
      end
    endcase

    result.ack_error = error_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_phase_r      <= PH_IDLE;
      tick_count_r     <= '0;
      bit_index_r      <= '0;
      shift_byte_r     <= '0;
      bytes_left_r     <= '0;
      poll_count_r     <= '0;
      error_flag_r     <= 1'b0;
      held_reg_addr_r  <= '0;
      held_wide_addr_r <= 1'b0;
      is_read_r        <= 1'b0;
      byte_stage_r     <= STG_ADDR;
    end else if (step_en) begin
      bus_phase_r      <= bus_phase_nxt;
      tick_count_r     <= tick_count_nxt;
      bit_index_r      <= bit_index_nxt;
      shift_byte_r     <= shift_byte_nxt;
      bytes_left_r     <= bytes_left_nxt;
      poll_count_r     <= poll_count_nxt;
      error_flag_r     <= error_flag_nxt;
      held_reg_addr_r  <= held_reg_addr_nxt;
      held_wide_addr_r <= held_wide_addr_nxt;
      is_read_r        <= is_read_nxt;
      byte_stage_r     <= byte_stage_nxt;
    end
  end

endmodule

FILE: rtl/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Each input transaction is one bus tick. The block takes one transaction per
// clock cycle and returns exactly one result transaction for it in the next
// cycle, through a single output register. The input is stalled only while
// that output register holds a result that the receiver is stalling, so the
// rate is one tick per cycle while the receiver does not stall; the phase
// counter and the bus sequencer state are updated in the accepting cycle.
// Configuration writes take effect on the next accepted tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  cfg_regs_t cfg_r;
  out_item_t step_result;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks    <= PHASE_TICKS_RESET;
      cfg_r.ack_poll_limit <= ACK_POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS:    cfg_r.phase_ticks    <= cfg_wdata;
        CFG_ACK_POLL_LIMIT: cfg_r.ack_poll_limit <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .item    (in_data),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
